// ===== sv/jnie_pkg.sv =====
// shared types and constants for the json nested integer extractor
// holds the request and result payload structs, character codes and register indexes
// no dependencies
package jnie_pkg;

  // one request: a document byte and its end marker
  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } jnie_in_t;

  // one result: status and parsed value
  typedef struct packed {
    logic               lookup_status;
    logic signed [31:0] found_value;
  } jnie_out_t;

  // configuration register indexes
  localparam logic [2:0] REG_BLOCK_NAME_LOW  = 3'd0;
  localparam logic [2:0] REG_BLOCK_NAME_HIGH = 3'd1;
  localparam logic [2:0] REG_BLOCK_NAME_LEN  = 3'd2;
  localparam logic [2:0] REG_KEY_NAME_LOW    = 3'd3;
  localparam logic [2:0] REG_KEY_NAME_HIGH   = 3'd4;
  localparam logic [2:0] REG_KEY_NAME_LEN    = 3'd5;

  // lookup status codes on the result
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  // character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // largest magnitude a 32-bit signed value can take (negative side)
  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

endpackage

// ===== sv/json_nested_int_extractor_top.sv =====
// top level of the json nested integer extractor
// byte-serial json scanner with a request register, one pass of parse logic and a result register
// depends on jnie_pkg
//
// Takes one JSON document a byte per request, with final_byte set on the last byte, and
// returns one result per document: status ok with the signed 32-bit integer found at
// "<block name>": { ... "<key name>": <int> ... }, or status error with value 0. A new
// byte is accepted every cycle while in_stall is low; each byte is held in the request
// register, is parsed by a single pass of logic that updates the scan state, and on the
// final byte the verdict is written to the result register, which drives out_valid.
// in_stall is raised only while a final byte waits in the request register and the result
// register still holds an untaken result. Block and key names are up to MAX_NAME_BYTES raw
// bytes and are compared without unescaping; brace depth is tracked in DEPTH_BITS bits and
// wraps. Configuration is written through cfg_* (always ready) and must only change while no
// document is in flight.
module json_nested_int_extractor_top
  import jnie_pkg::*;
#(
  parameter int MAX_NAME_BYTES = 16,
  parameter int DEPTH_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  jnie_in_t    in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output jnie_out_t   out_data,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [DEPTH_BITS-1:0] DepthOne  = DEPTH_BITS'(1);
  localparam logic [DEPTH_BITS-1:0] DepthZero = '0;
  localparam logic [4:0]            MaxLen    = 5'(MAX_NAME_BYTES);

  // scan phases
  typedef enum logic [3:0] {
    PH_SEEK_BLOCK,
    PH_BLOCK_STR,
    PH_BLOCK_COLON,
    PH_BLOCK_BRACE,
    PH_SEEK_KEY,
    PH_KEY_STR,
    PH_KEY_COLON,
    PH_NUM_START,
    PH_NUM_SIGNED,
    PH_NUM_DIGITS,
    PH_NUM_AFTER
  } phase_t;

  typedef enum logic [1:0] {
    DEC_UNDECIDED,
    DEC_OK,
    DEC_ERROR
  } decision_t;

  // ---------------------------------------------------------------------------
  // configuration registers: only the bytes the name compare can use are kept
  // ---------------------------------------------------------------------------
  logic [7:0] blk_name_r [MAX_NAME_BYTES];
  logic [7:0] key_name_r [MAX_NAME_BYTES];
  logic [4:0] blk_len_r;
  logic [4:0] key_len_r;

  assign cfg_ready = 1'b1;

  for (genvar gi = 0; gi < MAX_NAME_BYTES; gi++) begin : g_name
    // low register feeds bytes 0..7, high register bytes 8..15
    localparam int          Lane    = gi % 8;
    localparam logic [2:0]  BlkReg  = (gi < 8) ? REG_BLOCK_NAME_LOW : REG_BLOCK_NAME_HIGH;
    localparam logic [2:0]  KeyReg  = (gi < 8) ? REG_KEY_NAME_LOW : REG_KEY_NAME_HIGH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        blk_name_r[gi] <= '0;
        key_name_r[gi] <= '0;
      end else if (cfg_valid && cfg_ready) begin
        if (cfg_index == BlkReg) begin
          blk_name_r[gi] <= cfg_data[8*Lane +: 8];
        end
        if (cfg_index == KeyReg) begin
          key_name_r[gi] <= cfg_data[8*Lane +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_len_r <= '0;
      key_len_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_BLOCK_NAME_LEN) begin
        blk_len_r <= cfg_data[4:0];
      end
      if (cfg_index == REG_KEY_NAME_LEN) begin
        key_len_r <= cfg_data[4:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request register
  // ---------------------------------------------------------------------------
  logic      req_valid_r;
  jnie_in_t  req_r;
  logic      advance;
  logic      out_valid_r;
  jnie_out_t out_r;

  // a byte moves on unless it ends a document and the result slot is still occupied
  assign advance  = req_valid_r && (!req_r.final_byte || !out_valid_r || !out_stall);
  assign in_stall = req_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      req_valid_r <= 1'b1;
    end else if (advance) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r <= in_data;
    end
  end

  // ---------------------------------------------------------------------------
  // scan state
  // ---------------------------------------------------------------------------
  phase_t                phase_r, phase_nxt;
  logic [DEPTH_BITS-1:0] depth_r, depth_nxt;
  logic [4:0]            spos_r, spos_nxt;
  logic                  smatch_r, smatch_nxt;
  logic                  esc_r, esc_nxt;
  logic [31:0]           mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic                  ovf_r, ovf_nxt;
  decision_t             dstat_r, dstat_nxt;
  logic [31:0]           dval_r, dval_nxt;
  logic                  out_valid_nxt;
  jnie_out_t             out_nxt;

  // name compare for the byte at the current string position
  logic [7:0] b;
  logic [4:0] cur_len;
  logic       name_byte_eq;
  logic       name_hit;

  assign b = req_r.text_byte;

  always_comb begin
    cur_len      = (phase_r == PH_BLOCK_STR) ? blk_len_r : key_len_r;
    name_byte_eq = 1'b0;
    for (int i = 0; i < MAX_NAME_BYTES; i++) begin
      if (spos_r == 5'(i)) begin
        if (phase_r == PH_BLOCK_STR) begin
          name_byte_eq = (blk_name_r[i] == b);
        end else begin
          name_byte_eq = (key_name_r[i] == b);
        end
      end
    end
    name_hit = (spos_r < cur_len) && (cur_len <= MaxLen) && name_byte_eq;
  end

  // byte classes
  logic is_ws;
  logic is_digit;
  logic is_quote;
  logic is_end_sep;

  assign is_ws      = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  assign is_digit   = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_quote   = (b == CH_QUOTE);
  assign is_end_sep = (b == CH_COMMA) || (b == CH_RBRACE);

  // decimal accumulate: mag * 10 + digit, clamped at the limit
  logic [34:0] mag_acc;
  assign mag_acc = {mag_r, 3'b000} + {2'b00, mag_r, 1'b0} + {31'd0, 4'(b - CH_ZERO)};

  // in-range check of the collected number and its two's complement value
  logic        num_ok;
  logic [31:0] num_val;
  assign num_ok  = !ovf_r && (neg_r || !mag_r[31]);
  assign num_val = neg_r ? (32'd0 - mag_r) : mag_r;

  // end of string and the test for a full name match
  logic str_close;
  logic str_match;
  assign str_close = !esc_r && is_quote;
  assign str_match = (depth_r == DepthOne) && smatch_r && (spos_r == cur_len);

  logic        do_seek;
  logic        fin_ok;
  logic [31:0] fin_val;
  logic        num_ok_post;
  logic [31:0] num_val_post;

  always_comb begin
    phase_nxt     = phase_r;
    depth_nxt     = depth_r;
    spos_nxt      = spos_r;
    smatch_nxt    = smatch_r;
    esc_nxt       = esc_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    ovf_nxt       = ovf_r;
    dstat_nxt     = dstat_r;
    dval_nxt      = dval_r;
    do_seek       = 1'b0;
    fin_ok        = 1'b0;
    fin_val       = '0;
    num_ok_post   = 1'b0;
    num_val_post  = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    if (advance) begin
      // parse the byte unless the verdict is already known
      if (dstat_r == DEC_UNDECIDED) begin
        case (phase_r)
          PH_SEEK_BLOCK: begin
            do_seek = 1'b1;
          end
          PH_BLOCK_STR, PH_KEY_STR: begin
            if (str_close) begin
              if (str_match) begin
                phase_nxt = (phase_r == PH_BLOCK_STR) ? PH_BLOCK_COLON : PH_KEY_COLON;
              end else begin
                phase_nxt = (phase_r == PH_BLOCK_STR) ? PH_SEEK_BLOCK : PH_SEEK_KEY;
              end
            end else begin
              esc_nxt    = !esc_r && (b == CH_BSLASH);
              smatch_nxt = smatch_r && name_hit;
              if (spos_r != 5'd31) begin
                spos_nxt = spos_r + 5'd1;
              end
            end
          end
          PH_BLOCK_COLON: begin
            if (b == CH_COLON) begin
              phase_nxt = PH_BLOCK_BRACE;
            end else if (!is_ws) begin
              // near miss: rescan this byte as ordinary text
              phase_nxt = PH_SEEK_BLOCK;
              do_seek   = 1'b1;
            end
          end
          PH_BLOCK_BRACE: begin
            if (b == CH_LBRACE) begin
              phase_nxt = PH_SEEK_KEY;
              depth_nxt = DepthOne;
            end else if (!is_ws) begin
              phase_nxt = PH_SEEK_BLOCK;
              do_seek   = 1'b1;
            end
          end
          PH_SEEK_KEY: begin
            if (is_quote) begin
              phase_nxt  = PH_KEY_STR;
              spos_nxt   = '0;
              smatch_nxt = 1'b1;
              esc_nxt    = 1'b0;
            end else if (b == CH_LBRACE) begin
              depth_nxt = depth_r + DepthOne;
            end else if (b == CH_RBRACE) begin
              depth_nxt = depth_r - DepthOne;
              // block closed before the key showed up
              if (depth_r == DepthOne) begin
                dstat_nxt = DEC_ERROR;
                dval_nxt  = '0;
              end
            end
          end
          PH_KEY_COLON: begin
            if (b == CH_COLON) begin
              phase_nxt = PH_NUM_START;
            end else if (!is_ws) begin
              dstat_nxt = DEC_ERROR;
              dval_nxt  = '0;
            end
          end
          PH_NUM_START, PH_NUM_SIGNED: begin
            if ((phase_r == PH_NUM_START) && ((b == CH_MINUS) || (b == CH_PLUS))) begin
              neg_nxt   = (b == CH_MINUS);
              phase_nxt = PH_NUM_SIGNED;
            end else if (is_digit) begin
              phase_nxt = PH_NUM_DIGITS;
              if (mag_acc > {3'b000, MAG_LIMIT}) begin
                ovf_nxt = 1'b1;
                mag_nxt = MAG_LIMIT;
              end else begin
                mag_nxt = mag_acc[31:0];
              end
            end else if ((phase_r == PH_NUM_SIGNED) || !is_ws) begin
              dstat_nxt = DEC_ERROR;
              dval_nxt  = '0;
            end
          end
          PH_NUM_DIGITS: begin
            if (is_digit) begin
              if (!ovf_r) begin
                if (mag_acc > {3'b000, MAG_LIMIT}) begin
                  ovf_nxt = 1'b1;
                  mag_nxt = MAG_LIMIT;
                end else begin
                  mag_nxt = mag_acc[31:0];
                end
              end
            end else if (!num_ok) begin
              dstat_nxt = DEC_ERROR;
              dval_nxt  = '0;
            end else if (is_end_sep) begin
              dstat_nxt = DEC_OK;
              dval_nxt  = num_val;
            end else if (is_ws) begin
              dval_nxt  = num_val;
              phase_nxt = PH_NUM_AFTER;
            end else begin
              dstat_nxt = DEC_ERROR;
              dval_nxt  = '0;
            end
          end
          PH_NUM_AFTER: begin
            if (is_end_sep) begin
              dstat_nxt = DEC_OK;
            end else if (!is_ws) begin
              dstat_nxt = DEC_ERROR;
              dval_nxt  = '0;
            end
          end
          default: begin
            dstat_nxt = DEC_ERROR;
            dval_nxt  = '0;
          end
        endcase

        // plain scan outside the block: strings and brace depth
        if (do_seek) begin
          if (is_quote) begin
            phase_nxt  = PH_BLOCK_STR;
            spos_nxt   = '0;
            smatch_nxt = 1'b1;
            esc_nxt    = 1'b0;
          end else if (b == CH_LBRACE) begin
            depth_nxt = depth_r + DepthOne;
          end else if (b == CH_RBRACE) begin
            depth_nxt = depth_r - DepthOne;
          end
        end
      end

      // end of document: settle the verdict, load the result and clear the scan
      if (req_r.final_byte) begin
        num_ok_post  = !ovf_nxt && (neg_nxt || !mag_nxt[31]);
        num_val_post = neg_nxt ? (32'd0 - mag_nxt) : mag_nxt;
        if (dstat_nxt == DEC_OK) begin
          fin_ok  = 1'b1;
          fin_val = dval_nxt;
        end else if (dstat_nxt == DEC_UNDECIDED) begin
          if ((phase_nxt == PH_NUM_DIGITS) && num_ok_post) begin
            fin_ok  = 1'b1;
            fin_val = num_val_post;
          end else if (phase_nxt == PH_NUM_AFTER) begin
            fin_ok  = 1'b1;
            fin_val = dval_nxt;
          end
        end
        out_valid_nxt         = 1'b1;
        out_nxt.lookup_status = fin_ok ? STATUS_OK : STATUS_ERROR;
        out_nxt.found_value   = fin_ok ? fin_val : '0;

        phase_nxt  = PH_SEEK_BLOCK;
        depth_nxt  = DepthZero;
        spos_nxt   = '0;
        smatch_nxt = 1'b1;
        esc_nxt    = 1'b0;
        mag_nxt    = '0;
        neg_nxt    = 1'b0;
        ovf_nxt    = 1'b0;
        dstat_nxt  = DEC_UNDECIDED;
        dval_nxt   = '0;
      end
    end
  end

  // scan state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SEEK_BLOCK;
      depth_r     <= DepthZero;
      spos_r      <= '0;
      smatch_r    <= 1'b1;
      esc_r       <= 1'b0;
      mag_r       <= '0;
      neg_r       <= 1'b0;
      ovf_r       <= 1'b0;
      dstat_r     <= DEC_UNDECIDED;
      dval_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      depth_r     <= depth_nxt;
      spos_r      <= spos_nxt;
      smatch_r    <= smatch_nxt;
      esc_r       <= esc_nxt;
      mag_r       <= mag_nxt;
      neg_r       <= neg_nxt;
      ovf_r       <= ovf_nxt;
      dstat_r     <= dstat_nxt;
      dval_r      <= dval_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== sv/jnie_checker.sv =====
// port-level checks for the json nested integer extractor, bound to the top level
// depends on jnie_pkg and json_nested_int_extractor_top
module jnie_checker
  import jnie_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input jnie_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input jnie_out_t out_data
);

  // a held result keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an error result carries a zero value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.lookup_status == STATUS_ERROR) |-> (out_data.found_value == 32'sd0))
    else $error("error result with nonzero value");

  // a new result follows an accepted final byte
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_data.final_byte, 2))
    else $error("result without a final byte");

  // no result right after reset
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind json_nested_int_extractor_top jnie_checker u_jnie_checker (.*);
